[design/tam_pkg.sv]
`default_nettype none

package tam_pkg;

  // default widths handed to the top level
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int PHASE_BITS_DEF  = 32;

  // fixed design constants
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_DEPTH_LOG   = $clog2(SINE_TABLE_DEPTH);
  localparam int SAMPLE_RATE_HZ   = 48000;

  // sine polynomial coefficients, Q14
  localparam int POLY_C1 = 25734;
  localparam int POLY_C3 = 10543;
  localparam int POLY_C5 = 1193;

  // one-pole smoother weights, Q16
  localparam int TRI_OLD_WEIGHT = 65470;
  localparam int TRI_NEW_WEIGHT = 66;

  // configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [7:0] SPEED_RESET  = 8'd69;
  localparam logic [7:0] DEPTH_RESET  = 8'd69;
  localparam logic       WAVE_RESET   = 1'b0;
  localparam logic [7:0] VOLUME_RESET = 8'd69;

  typedef enum logic [1:0] {
    REG_SPEED  = 2'd0,
    REG_DEPTH  = 2'd1,
    REG_WAVE   = 2'd2,
    REG_VOLUME = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] speed;
    logic [7:0] depth;
    logic       wave;
    logic [7:0] volume;
  } cfg_regs_t;

  // dry gain, Q1.15, 1 down to 0
  typedef logic [15:0] depth_tab_t [256];
  // output gain, Q2.15, 0 to 3
  typedef logic [16:0] volume_tab_t [256];

  function automatic depth_tab_t build_depth_gain();
    depth_tab_t t;
    for (int r = 0; r < 256; r++) begin
      t[r] = 16'(((255 - r) * 32768 + 127) / 255);
    end
    return t;
  endfunction

  function automatic volume_tab_t build_volume_gain();
    volume_tab_t t;
    for (int r = 0; r < 256; r++) begin
      t[r] = 17'((3 * r * 32768 + 127) / 255);
    end
    return t;
  endfunction

  localparam depth_tab_t  DEPTH_GAIN  = build_depth_gain();
  localparam volume_tab_t VOLUME_GAIN = build_volume_gain();

  // microcode fields
  typedef enum logic [2:0] {
    A_F     = 3'd0,
    A_W     = 3'd1,
    A_SM    = 3'd2,
    A_TRI   = 3'd3,
    A_DINV  = 3'd4,
    A_X     = 3'd5,
    A_K1193 = 3'd6
  } a_sel_t;

  typedef enum logic [2:0] {
    B_F      = 3'd0,
    B_X2     = 3'd1,
    B_W      = 3'd2,
    B_MOD    = 3'd3,
    B_VOL    = 3'd4,
    B_K65470 = 3'd5,
    B_K66    = 3'd6
  } b_sel_t;

  typedef enum logic [1:0] {
    RND_ZERO = 2'd0,
    RND_Q15  = 2'd1,
    RND_Q16  = 2'd2
  } rnd_sel_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_14 = 2'd1,
    SH_15 = 2'd2,
    SH_16 = 2'd3
  } shift_sel_t;

  typedef enum logic [1:0] {
    OP_PASS = 2'd0,
    OP_KSUB = 2'd1,
    OP_DADD = 2'd2,
    OP_SINE = 2'd3
  } res_op_t;

  typedef enum logic {
    K_POLY3 = 1'b0,
    K_POLY1 = 1'b1
  } kconst_sel_t;

  typedef enum logic [2:0] {
    DST_NONE  = 3'd0,
    DST_PHASE = 3'd1,
    DST_X2    = 3'd2,
    DST_W     = 3'd3,
    DST_MOD   = 3'd4,
    DST_SM    = 3'd5,
    DST_ACC   = 3'd6,
    DST_OUT   = 3'd7
  } dest_t;

  typedef enum logic [1:0] {
    JMP_NEXT   = 2'd0,
    JMP_TRI    = 2'd1,
    JMP_ALWAYS = 2'd2,
    JMP_END    = 2'd3
  } jump_t;

  localparam int UCODE_DEPTH = 18;
  localparam int STEP_BITS   = $clog2(UCODE_DEPTH);

  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_START = step_t'(0);
  localparam step_t STEP_TRI   = step_t'(9);
  localparam step_t STEP_GAIN  = step_t'(12);

  typedef struct packed {
    a_sel_t      a_sel;
    b_sel_t      b_sel;
    logic        mul_en;
    rnd_sel_t    rnd;
    logic        use_acc;
    shift_sel_t  shift;
    res_op_t     op;
    kconst_sel_t ksel;
    dest_t       dest;
    jump_t       jump;
    step_t       target;
  } ucode_t;

  typedef struct packed {
    logic   step_en;
    ucode_t word;
  } seq_ctrl_t;

  function automatic ucode_t step_word(a_sel_t a, b_sel_t b, logic mul, rnd_sel_t rnd,
                                       logic use_acc, shift_sel_t sh, res_op_t op,
                                       kconst_sel_t k, dest_t dst, jump_t jmp, step_t tgt);
    ucode_t w;
    w.a_sel   = a;
    w.b_sel   = b;
    w.mul_en  = mul;
    w.rnd     = rnd;
    w.use_acc = use_acc;
    w.shift   = sh;
    w.op      = op;
    w.ksel    = k;
    w.dest    = dst;
    w.jump    = jmp;
    w.target  = tgt;
    return w;
  endfunction

  // program: phase step, sine or triangle modulator, then gain chain
  localparam ucode_t UCODE_ROM [UCODE_DEPTH] = '{
    // 0: advance lfo, branch to triangle
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_PHASE, JMP_TRI, STEP_TRI),
    // 1..8: sine polynomial
    step_word(A_F, B_F, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b0, SH_14, OP_PASS, K_POLY3,
              DST_X2, JMP_NEXT, STEP_START),
    step_word(A_K1193, B_X2, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b0, SH_14, OP_KSUB, K_POLY3,
              DST_W, JMP_NEXT, STEP_START),
    step_word(A_W, B_X2, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b0, SH_14, OP_KSUB, K_POLY1,
              DST_W, JMP_NEXT, STEP_START),
    step_word(A_W, B_F, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b0, SH_14, OP_SINE, K_POLY3,
              DST_MOD, JMP_ALWAYS, STEP_GAIN),
    // 9..11: smoothed triangle
    step_word(A_SM, B_K65470, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_TRI, B_K66, 1'b1, RND_Q16, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_ACC, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_ZERO, 1'b1, SH_16, OP_PASS, K_POLY3,
              DST_SM, JMP_NEXT, STEP_START),
    // 12..17: gain and output
    step_word(A_DINV, B_MOD, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_Q15, 1'b0, SH_15, OP_DADD, K_POLY3,
              DST_W, JMP_NEXT, STEP_START),
    step_word(A_W, B_VOL, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_Q15, 1'b0, SH_15, OP_PASS, K_POLY3,
              DST_W, JMP_NEXT, STEP_START),
    step_word(A_X, B_W, 1'b1, RND_ZERO, 1'b0, SH_0, OP_PASS, K_POLY3,
              DST_NONE, JMP_NEXT, STEP_START),
    step_word(A_F, B_F, 1'b0, RND_Q15, 1'b0, SH_15, OP_PASS, K_POLY3,
              DST_OUT, JMP_END, STEP_START)
  };

endpackage

`default_nettype wire

[design/tam_sequencer.sv]
`default_nettype none

module tam_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                tri_sel,
  input  logic                out_free,
  output tam_pkg::seq_ctrl_t  ctrl,
  output logic                x_load,
  output logic                out_load
);
  import tam_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  step_t      pc_r, pc_nxt;
  ucode_t     word;
  logic       run;
  logic       stall;

  assign word  = UCODE_ROM[pc_r];
  assign run   = (state_r == SEQ_RUN);
  // last step waits until the output register is free
  assign stall = run && (word.jump == JMP_END) && !out_free;

  assign ctrl.step_en = run && !stall;
  assign ctrl.word    = word;

  assign in_ready = (state_r == SEQ_IDLE);
  assign x_load   = in_valid && in_ready;
  assign out_load = ctrl.step_en && (word.dest == DST_OUT);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    case (state_r)
      SEQ_IDLE: begin
        if (x_load) begin
          state_nxt = SEQ_RUN;
          pc_nxt    = STEP_START;
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          case (word.jump)
            JMP_NEXT:   pc_nxt = step_t'(pc_r + 1'b1);
            JMP_TRI:    pc_nxt = tri_sel ? word.target : step_t'(pc_r + 1'b1);
            JMP_ALWAYS: pc_nxt = word.target;
            JMP_END:    state_nxt = SEQ_IDLE;
            default:    state_nxt = SEQ_IDLE;
          endcase
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      pc_r    <= STEP_START;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

[design/tam_datapath.sv]
`default_nettype none

module tam_datapath #(
  parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = tam_pkg::PHASE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tam_pkg::seq_ctrl_t            ctrl,
  input  tam_pkg::cfg_regs_t            cfg,
  input  logic                          x_load,
  input  logic signed [SAMPLE_BITS-1:0] x_in,
  output logic signed [SAMPLE_BITS-1:0] y_out,
  output logic                          clip_out
);
  import tam_pkg::*;

  localparam int AW = (SAMPLE_BITS > 18) ? SAMPLE_BITS : 18;
  localparam int BW = 18;
  localparam int PW = AW + BW;
  localparam int SW = PW + 1;

  localparam logic [63:0] INC_DEN = 64'(510 * SAMPLE_RATE_HZ);

  typedef logic [PHASE_BITS-1:0] inc_tab_t [256];

  // phase increment per speed setting, rounded
  function automatic inc_tab_t build_inc();
    inc_tab_t    t;
    logic [63:0] num;
    for (int r = 0; r < 256; r++) begin
      num  = 64'(255 + 19 * r) << PHASE_BITS;
      t[r] = PHASE_BITS'((num + INC_DEN / 2) / INC_DEN);
    end
    return t;
  endfunction

  localparam inc_tab_t INC_TABLE = build_inc();

  localparam logic signed [SW-1:0] Y_MAX =
    {{(SW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SW-1:0] Y_MIN = ~Y_MAX;

  logic [PHASE_BITS-1:0]         phase_r;
  logic [15:0]                   sm_r;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [PW-1:0]          prod_r;
  logic signed [SW-1:0]          acc_r;
  logic [14:0]                   x2_r;
  logic [16:0]                   w_r;
  logic [15:0]                   mod_r;

  ucode_t uw;
  assign uw = ctrl.word;

  // sine angle: quadrant and mirrored fraction
  logic [1:0]                quad;
  logic [SINE_DEPTH_LOG-1:0] sidx;
  logic [15:0]               uang;
  logic [14:0]               f_raw;
  logic [14:0]               f_val;

  assign quad  = phase_r[PHASE_BITS-1 -: 2];
  assign sidx  = phase_r[PHASE_BITS-1 -: SINE_DEPTH_LOG];
  assign uang  = 16'(sidx) << (16 - SINE_DEPTH_LOG);
  assign f_raw = {1'b0, uang[13:0]};
  assign f_val = quad[0] ? 15'd16384 - f_raw : f_raw;

  // triangle over one lfo period
  logic [14:0] tri_pos;
  logic [15:0] tri_val;

  assign tri_pos = phase_r[PHASE_BITS-1 -: 15];
  assign tri_val = tri_pos[14] ? 16'((17'd32768 - 17'(tri_pos)) << 1) : {tri_pos, 1'b0};

  // gains from the settings
  logic [15:0]           dgain;
  logic [15:0]           dinv;
  logic [16:0]           vgain;
  logic [PHASE_BITS-1:0] inc_val;

  assign dgain   = DEPTH_GAIN[cfg.depth];
  assign dinv    = 16'(17'd32768 - 17'(dgain));
  assign vgain   = VOLUME_GAIN[cfg.volume];
  assign inc_val = INC_TABLE[cfg.speed];

  // shared multiplier
  logic signed [AW-1:0] a_op;
  logic signed [BW-1:0] b_op;
  logic signed [PW-1:0] mul_full;

  always_comb begin
    case (uw.a_sel)
      A_F:     a_op = AW'(f_val);
      A_W:     a_op = AW'(w_r);
      A_SM:    a_op = AW'(sm_r);
      A_TRI:   a_op = AW'(tri_val);
      A_DINV:  a_op = AW'(dinv);
      A_X:     a_op = AW'(x_r);
      A_K1193: a_op = AW'(POLY_C5);
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (uw.b_sel)
      B_F:      b_op = BW'(f_val);
      B_X2:     b_op = BW'(x2_r);
      B_W:      b_op = BW'(w_r);
      B_MOD:    b_op = BW'(mod_r);
      B_VOL:    b_op = BW'(vgain);
      B_K65470: b_op = BW'(TRI_OLD_WEIGHT);
      B_K66:    b_op = BW'(TRI_NEW_WEIGHT);
      default:  b_op = '0;
    endcase
  end

  assign mul_full = a_op * b_op;

  // add, round, shift
  logic signed [SW-1:0] rnd_val;
  logic signed [SW-1:0] acc_in;
  logic signed [SW-1:0] sum_val;
  logic signed [SW-1:0] shifted;

  always_comb begin
    case (uw.rnd)
      RND_Q15: rnd_val = SW'(16384);
      RND_Q16: rnd_val = SW'(32768);
      default: rnd_val = '0;
    endcase
  end

  assign acc_in  = uw.use_acc ? acc_r : '0;
  assign sum_val = SW'(prod_r) + acc_in + rnd_val;

  always_comb begin
    case (uw.shift)
      SH_14:   shifted = sum_val >>> 14;
      SH_15:   shifted = sum_val >>> 15;
      SH_16:   shifted = sum_val >>> 16;
      default: shifted = sum_val;
    endcase
  end

  logic [14:0] sine_s;
  logic [16:0] kval;
  logic [16:0] res_val;

  assign sine_s = (shifted > SW'(16384)) ? 15'd16384 : shifted[14:0];
  assign kval   = (uw.ksel == K_POLY1) ? 17'(POLY_C1) : 17'(POLY_C3);

  always_comb begin
    case (uw.op)
      OP_KSUB: res_val = kval - shifted[16:0];
      OP_DADD: res_val = 17'(dgain) + shifted[16:0];
      OP_SINE: res_val = quad[1] ? 17'd16384 - 17'(sine_s) : 17'd16384 + 17'(sine_s);
      default: res_val = shifted[16:0];
    endcase
  end

  // saturation to the sample width
  always_comb begin
    if (shifted > Y_MAX) begin
      y_out    = Y_MAX[SAMPLE_BITS-1:0];
      clip_out = 1'b1;
    end else if (shifted < Y_MIN) begin
      y_out    = Y_MIN[SAMPLE_BITS-1:0];
      clip_out = 1'b1;
    end else begin
      y_out    = shifted[SAMPLE_BITS-1:0];
      clip_out = 1'b0;
    end
  end

  // lfo state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sm_r    <= '0;
    end else if (ctrl.step_en) begin
      case (uw.dest)
        DST_PHASE: phase_r <= phase_r + inc_val;
        DST_SM:    sm_r    <= shifted[15:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (x_load) begin
      x_r <= x_in;
    end
    if (ctrl.step_en) begin
      if (uw.mul_en) begin
        prod_r <= mul_full;
      end
      case (uw.dest)
        DST_X2:  x2_r  <= res_val[14:0];
        DST_W:   w_r   <= res_val;
        DST_MOD: mod_r <= res_val[15:0];
        DST_SM:  mod_r <= shifted[15:0];
        DST_ACC: acc_r <= sum_val;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[design/tremolo_amplitude_modulator_unit.sv]
`default_nettype none

// channel   direction  ports                                      accepted when
// input     in         in_valid, in_ready, in_sample_in           in_valid && in_ready
// result    out        out_valid, out_ready, out_sample_out,      out_valid && out_ready
//                      out_clipped
// config    in         psel, penable, pwrite, paddr, pwdata,      psel && penable && pwrite
//                      prdata, pready
//
// an item takes longer from acceptance to a valid result with the sine modulator than with
// the triangle, as the sine program has more steps; the next item is taken only after the
// last program step, with all products on the single shared multiplier, one item in flight
// at a time
// reset clears the lfo phase and the smoothed triangle and loads the setting defaults
// a finished result sits in the output register, and the next item is taken while it
// waits; only the last program step holds if that result is still unread

module tremolo_amplitude_modulator_unit #(
  parameter int SAMPLE_BITS = tam_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS  = tam_pkg::PHASE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input items
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_in,
  // result items
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_clipped,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tam_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [tam_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [tam_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import tam_pkg::*;

  // ------------------------------------------------------------------
  // settings registers, one word each
  // ------------------------------------------------------------------
  cfg_regs_t cfg_r, cfg_nxt;
  reg_idx_t  reg_idx;
  logic      cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        REG_SPEED:  cfg_nxt.speed  = pwdata[7:0];
        REG_DEPTH:  cfg_nxt.depth  = pwdata[7:0];
        REG_WAVE:   cfg_nxt.wave   = pwdata[0];
        REG_VOLUME: cfg_nxt.volume = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back, upper bits zero
  always_comb begin
    case (reg_idx)
      REG_SPEED:  prdata = CFG_DATA_BITS'(cfg_r.speed);
      REG_DEPTH:  prdata = CFG_DATA_BITS'(cfg_r.depth);
      REG_WAVE:   prdata = CFG_DATA_BITS'(cfg_r.wave);
      REG_VOLUME: prdata = CFG_DATA_BITS'(cfg_r.volume);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.speed  <= SPEED_RESET;
      cfg_r.depth  <= DEPTH_RESET;
      cfg_r.wave   <= WAVE_RESET;
      cfg_r.volume <= VOLUME_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ------------------------------------------------------------------
  // sequencer and datapath
  // ------------------------------------------------------------------
  seq_ctrl_t                     ctrl;
  logic                          x_load;
  logic                          out_load;
  logic                          out_free;
  logic signed [SAMPLE_BITS-1:0] y_val;
  logic                          clip_val;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_clipped_r;

  // output register is free if empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  tam_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .tri_sel  (cfg_r.wave),
    .out_free (out_free),
    .ctrl     (ctrl),
    .x_load   (x_load),
    .out_load (out_load)
  );

  tam_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .cfg      (cfg_r),
    .x_load   (x_load),
    .x_in     (in_sample_in),
    .y_out    (y_val),
    .clip_out (clip_val)
  );

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r  <= y_val;
      out_clipped_r <= clip_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clipped_r;

endmodule

`default_nettype wire
